// ===== sv/sbi_pkg.sv =====
// Shared types and operation codes for the sorted breakpoint interpolator.
package sbi_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic               ins;   // shift-insert this cycle
        logic               clr;   // empty the table
        logic signed [31:0] pos;
        logic signed [31:0] val;
    } t_cell_cmd;

endpackage

// ===== sv/sbi_cell.sv =====
// One breakpoint slot of the sorted chain: holds a point and shifts on insert.
module sbi_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbi_pkg::t_cell_cmd  i_cmd,
    input  logic                i_prev_valid,
    input  logic                i_prev_gt,
    input  logic signed [31:0]  i_prev_pos,
    input  logic signed [31:0]  i_prev_val,
    output logic                o_valid,
    output logic                o_gt,
    output logic signed [31:0]  o_pos,
    output logic signed [31:0]  o_val
);
    logic               r_valid;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_val;

    // Slot holds a point strictly above the broadcast position
    assign o_gt    = r_valid && (r_pos > i_cmd.pos);
    assign o_valid = r_valid;
    assign o_pos   = r_pos;
    assign o_val   = r_val;

    // Hold valid; fill the first empty slot on insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    // Take the neighbour's point when it moves up, else the new point, or hold
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && i_prev_valid) begin
            if (i_prev_gt) begin
                r_pos <= i_prev_pos;
                r_val <= i_prev_val;
            end else if (o_gt || !r_valid) begin
                r_pos <= i_cmd.pos;
                r_val <= i_cmd.val;
            end
        end
    end
endmodule

// ===== sv/sbi_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit by 33-bit unsigned.
module sbi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_quo;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_sh;
    logic [34:0] w_sub;

    assign w_sh  = {r_rem[32:0], r_quo[63]};
    assign w_sub = {1'b0, w_sh} - {2'b00, r_den};
    assign o_quo = r_quo;

    // Advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[34]) begin
                r_rem <= w_sub[33:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end
endmodule

// ===== sv/sorted_breakpoint_interpolator_top.sv =====
// Top level: chain of breakpoint cells, search, multiply, divide and output register.
// Sorted breakpoint interpolator.
// Input channel (i_valid/o_stall) takes operation, abscissa, ordinate; output
// channel (o_valid/i_stall) gives one result beat per input beat.
// Points live in a row of CAPACITY cells; each cell compares its point with the
// broadcast position, so an insert shifts all the larger points up by one at
// once and a query finds its bracketing pair combinationally.
// Insert, clear and no-op pass through states S_OP and S_WAIT to the result.
// Query: select pair, then 32x32 multiply (cut into two 32x16 partials in
// states S_MUL0 and S_MUL1), then a restoring divider, then saturate. A query
// with no bracketing pair gives zero, not in range. The divider sets the query
// rate; one item is in flight at a time.
// A new item is accepted as soon as the previous result sits in the output
// register, even while that result is stalled.
// Reset (synchronous, active low) empties the table and the output register.
// While i_stall is high the output beat holds unchanged.
module sorted_breakpoint_interpolator_top #(
    parameter int CAPACITY      = 128,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_abscissa,
    input  logic signed [31:0] i_ordinate,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_interpolated,
    output logic               o_in_range,
    output logic               o_insert_dropped,
    output logic [7:0]         o_stored_count
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_MUL0 = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0]  r_state;
    logic [1:0]  r_op;
    logic signed [31:0] r_pos, r_val;
    logic [CW-1:0] r_cnt;

    // Result of the item in flight, kept apart from the output beat
    logic signed [31:0] r_res_interp;
    logic               r_res_inr;
    logic               r_res_drop;
    logic [7:0]         r_res_cnt;

    sbi_pkg::t_cell_cmd w_cmd;
    logic [CAPACITY:0]  w_valid, w_gt;
    logic signed [31:0] w_pos [CAPACITY+1];
    logic signed [31:0] w_val [CAPACITY+1];

    // Static fraction width only labels the format; arithmetic is ratio based
    logic [7:0] w_fb_unused;
    assign w_fb_unused = 8'(FRACTION_BITS);

    assign w_cmd.pos = r_pos;
    assign w_cmd.val = r_val;
    assign w_cmd.clr = (r_state == S_OP) && (r_op == sbi_pkg::OP_CLEAR);
    assign w_cmd.ins = (r_state == S_OP) && (r_op == sbi_pkg::OP_INSERT)
                       && (r_cnt < CW'(CAPACITY));

    // Virtual head of the chain: always present, never above
    assign w_valid[0] = 1'b1;
    assign w_gt[0]    = 1'b0;
    assign w_pos[0]   = '0;
    assign w_val[0]   = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sbi_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_valid (w_valid[g]),
            .i_prev_gt    (w_gt[g]),
            .i_prev_pos   (w_pos[g]),
            .i_prev_val   (w_val[g]),
            .o_valid      (w_valid[g+1]),
            .o_gt         (w_gt[g+1]),
            .o_pos        (w_pos[g+1]),
            .o_val        (w_val[g+1])
        );
    end

    // Bracket select: first cell above the query, with a held cell below it
    logic               w_hit;
    logic signed [31:0] w_xl, w_xr, w_vl, w_vr;
    always_comb begin
        w_hit = 1'b0;
        w_xl = '0; w_xr = '0; w_vl = '0; w_vr = '0;
        for (int k = 1; k < CAPACITY; k++) begin
            if (w_gt[k+1] && !w_gt[k] && w_valid[k]) begin
                w_hit = 1'b1;
                w_xl = w_pos[k]; w_xr = w_pos[k+1];
                w_vl = w_val[k]; w_vr = w_val[k+1];
            end
        end
    end

    logic [32:0] r_den;
    logic [31:0] r_dx, r_mag;
    logic        r_neg;
    logic signed [31:0] r_vl;
    logic [63:0] r_prod;
    logic [47:0] r_plo;
    logic        r_dstart;
    logic        w_ddone;
    logic [63:0] w_quo;

    logic signed [32:0] w_dh;
    assign w_dh = 33'(w_vr) - 33'(w_vl);

    sbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    // Signed result: vl +/- quotient, clamped to 32 bits
    logic signed [65:0] w_sum;
    logic signed [31:0] w_sat;
    always_comb begin
        w_sum = r_neg ? (66'(r_vl) - $signed({2'b00, w_quo}))
                      : (66'(r_vl) + $signed({2'b00, w_quo}));
        if (w_sum > 66'sd2147483647)       w_sat = 32'sh7fffffff;
        else if (w_sum < -66'sd2147483648) w_sat = 32'sh80000000;
        else                               w_sat = w_sum[31:0];
    end

    logic w_out_free;
    assign w_out_free = !o_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);

    logic [CW-1:0] w_cnt_nx;
    always_comb begin
        w_cnt_nx = r_cnt;
        if (w_cmd.clr) w_cnt_nx = '0;
        else if (w_cmd.ins) w_cnt_nx = r_cnt + CW'(1);
    end

    // Sequence one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= (r_state == S_MUL1);
            if (o_valid && !i_stall && (r_state != S_WAIT)) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_operation;
                        r_pos   <= i_abscissa;
                        r_val   <= i_ordinate;
                        r_state <= S_OP;
                    end
                end
                S_OP: begin
                    r_cnt <= w_cnt_nx;
                    if (r_op == sbi_pkg::OP_QUERY && w_hit) begin
                        r_den   <= 33'(w_xr) - 33'(w_xl);
                        r_dx    <= 32'(33'(r_pos) - 33'(w_xl));
                        r_neg   <= w_dh[32];
                        r_mag   <= w_dh[32] ? 32'(-w_dh) : w_dh[31:0];
                        r_vl    <= w_vl;
                        r_state <= S_MUL0;
                    end else begin
                        r_state <= S_WAIT;
                    end
                    r_res_interp <= '0;
                    r_res_inr    <= 1'b0;
                    r_res_drop   <= (r_op == sbi_pkg::OP_INSERT)
                                    && (r_cnt >= CW'(CAPACITY));
                    r_res_cnt    <= 8'(w_cnt_nx);
                end
                S_MUL0: begin
                    r_plo   <= 48'(r_dx) * 48'(r_mag[15:0]);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod   <= {16'd0, r_plo}
                                + ({16'd0, 48'(r_dx) * 48'(r_mag[31:16])} << 16);
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_res_interp <= w_sat;
                        r_res_inr    <= 1'b1;
                        r_state      <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // Move the result into the output beat once it is free
                    if (w_out_free) begin
                        o_valid          <= 1'b1;
                        o_interpolated   <= r_res_interp;
                        o_in_range       <= r_res_inr;
                        o_insert_dropped <= r_res_drop;
                        o_stored_count   <= r_res_cnt;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Index width kept for table sizing
    logic [IW-1:0] w_idx_unused;
    assign w_idx_unused = IW'(r_cnt);
endmodule
